>>> sv/cbp_pkg.sv
// cbp_pkg: shared constants, state type and divider control and status types for coupon_bond_price
// used by cbp_div, coupon_bond_price and cbp_checker; no dependencies
`timescale 1ns / 1ps

package cbp_pkg;

    localparam int FRAC_BITS            = 32;
    localparam int MAX_MATURITY_YEARS   = 100;
    localparam int MAX_COUPONS_PER_YEAR = 12;

    // input field widths
    localparam int YIELD_W = 16;
    localparam int RATE_W  = 16;
    localparam int FACE_W  = 32;
    localparam int FREQ_W  = 4;
    localparam int YEARS_W = 7;
    localparam int PRICE_W = 48;

    // datapath widths
    localparam int D_W    = FRAC_BITS + 1;            // d and running power, up to 1.0
    localparam int N_W    = YEARS_W + FREQ_W;         // period count
    localparam int SUM_W  = N_W + D_W - 1;            // sum of up to 1200 powers
    localparam int X_W    = FACE_W + RATE_W;          // face times rate
    localparam int ACC_W  = X_W + SUM_W;              // face * rate * sum
    localparam int REM_W  = FREQ_W + YIELD_W;         // divider remainder and divisor
    localparam int MUL_W  = D_W;                      // shared multiplier operand
    localparam int PROD_W = 2 * MUL_W;
    localparam int ITER_W = $clog2(ACC_W + 1);

    // partial product split for the coupon numerator
    localparam int XLO_W = X_W / 2;
    localparam int XHI_W = X_W - XLO_W;
    localparam int SLO_W = SUM_W / 2 + 1;
    localparam int SHI_W = SUM_W - SLO_W;

    // rounding shifts
    localparam int CP_SHIFT = FRAC_BITS + 8;
    localparam int CP_W     = ACC_W + 1 - CP_SHIFT;
    localparam int FP_SHIFT = FRAC_BITS - 8;
    localparam int FP_W     = PROD_W - FP_SHIFT;
    localparam int PSUM_W   = CP_W + 1;

    localparam int DIV_ITERS_D = FRAC_BITS + 1;
    localparam int DIV_ITERS_C = ACC_W;

    localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
    localparam logic [D_W-1:0]     ONE_FX    = D_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVD_GO,
        ST_DIVD_WAIT,
        ST_PWR,
        ST_FR,
        ST_MACC,
        ST_DIVC_GO,
        ST_DIVC_WAIT,
        ST_FACE,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> sv/cbp_div.sv
// cbp_div: shared restoring divider, one quotient bit per cycle, dividend shifted msb first
// depends on cbp_pkg
`timescale 1ns / 1ps

module cbp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cbp_pkg::div_ctl_t           ctl,
    input  logic [cbp_pkg::REM_W-1:0]   init_rem,
    input  logic [cbp_pkg::ACC_W-1:0]   init_dvd,
    input  logic [cbp_pkg::REM_W-1:0]   divisor,
    output cbp_pkg::div_stat_t          stat,
    output logic [cbp_pkg::ACC_W-1:0]   quot
);
    import cbp_pkg::*;

    logic [REM_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  dvd_reg;
    logic [REM_W-1:0]  div_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W:0]    rem_sh;
    logic              ge;
    logic [REM_W-1:0]  rem_next;

    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[ACC_W-1]};
        ge       = rem_sh >= {1'b0, div_reg};
        rem_next = ge ? REM_W'(rem_sh - {1'b0, div_reg}) : rem_sh[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (ctl.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctl.iters;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg <= init_rem;
            dvd_reg <= init_dvd;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[ACC_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = dvd_reg;

endmodule

>>> sv/coupon_bond_price.sv
// Fixed-coupon bond present value. One bond is taken per transfer and one price is returned
// per bond. A bond with n = maturity_years * coupons_per_year periods passes through the
// discount power loop, one period per cycle through the single shared multiplier, and the
// bit-serial divider, which runs once for the discount factor (33 steps) and once for the
// coupon split (91 steps). s_ready is high only between bonds; a finished price waits in
// the output register, so the next bond may be taken before it is read.
// depends on cbp_pkg and cbp_div
`timescale 1ns / 1ps

module coupon_bond_price (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cbp_pkg::YIELD_W-1:0]   s_annual_yield,
    input  logic [cbp_pkg::RATE_W-1:0]    s_coupon_frac,
    input  logic [cbp_pkg::FACE_W-1:0]    s_par_amount,
    input  logic [cbp_pkg::FREQ_W-1:0]    s_coupons_per_year,
    input  logic [cbp_pkg::YEARS_W-1:0]   s_maturity_years,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cbp_pkg::PRICE_W-1:0]   m_bond_price
);
    import cbp_pkg::*;

    state_t state_reg, state_next;

    logic [FACE_W-1:0]  face_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [N_W-1:0]     n_reg;
    logic [REM_W-1:0]   den_reg;
    logic [D_W-1:0]     d_reg;
    logic [D_W-1:0]     p_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [N_W-1:0]     cnt_reg;
    logic [X_W-1:0]     x_reg;
    logic [2:0]         k_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [CP_W-1:0]    cp_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [PRICE_W-1:0] m_bond_price_reg;
    logic               m_valid_reg;

    logic               accept;
    logic               out_free;
    logic [FREQ_W-1:0]  freq_c;
    logic [YEARS_W-1:0] years_c;
    logic [N_W-1:0]     n_c;
    logic [REM_W-1:0]   num_c;
    logic [REM_W-1:0]   den_c;
    logic [D_W:0]       d_c;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]  p_rnd;
    logic [D_W-1:0]     p_new;
    logic [2:0]         km1;
    logic [5:0]         acc_sh;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W:0]     cp_rnd;
    logic [PROD_W-1:0]  fp_rnd;
    logic [FP_W-1:0]    fp_c;
    logic [PSUM_W-1:0]  psum;

    div_ctl_t           div_ctl;
    div_stat_t          div_stat;
    logic [REM_W-1:0]   div_rem;
    logic [ACC_W-1:0]   div_dvd;
    logic [REM_W-1:0]   div_den;
    logic [ACC_W-1:0]   quot;

    cbp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .init_rem (div_rem),
        .init_dvd (div_dvd),
        .divisor  (div_den),
        .stat     (div_stat),
        .quot     (quot)
    );

    // input clamps and setup values
    always_comb begin
        accept = s_valid && s_ready;
        priority if (s_coupons_per_year == '0) begin
            freq_c = FREQ_W'(1);
        end else if (s_coupons_per_year > FREQ_W'(MAX_COUPONS_PER_YEAR)) begin
            freq_c = FREQ_W'(MAX_COUPONS_PER_YEAR);
        end else begin
            freq_c = s_coupons_per_year;
        end
        years_c = (s_maturity_years > YEARS_W'(MAX_MATURITY_YEARS)) ?
                  YEARS_W'(MAX_MATURITY_YEARS) : s_maturity_years;
        n_c     = N_W'(years_c) * N_W'(freq_c);
        num_c   = {freq_c, {YIELD_W{1'b0}}};
        den_c   = num_c + REM_W'(s_annual_yield);
        d_c     = {1'b0, quot[D_W-1:0]} + (D_W+1)'(1);
    end

    // shared multiplier and rounding paths
    always_comb begin
        mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
        p_rnd  = mul_p + (PROD_W'(1) << (FRAC_BITS - 1));
        p_new  = D_W'(p_rnd >> FRAC_BITS);
        km1    = k_reg - 3'd1;
        acc_sh = (km1[0] ? 6'(XLO_W) : 6'd0) + (km1[1] ? 6'(SLO_W) : 6'd0);
        addend = ACC_W'(prod_reg) << acc_sh;
        cp_rnd = {1'b0, quot} + ((ACC_W+1)'(1) << (CP_SHIFT - 1));
        fp_rnd = prod_reg + (PROD_W'(1) << (FP_SHIFT - 1));
        fp_c   = FP_W'(fp_rnd >> FP_SHIFT);
        psum   = PSUM_W'(cp_reg) + PSUM_W'(fp_c);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_DIVD_GO;
            ST_DIVD_GO:   state_next = ST_DIVD_WAIT;
            ST_DIVD_WAIT: if (div_stat.done) state_next = ST_PWR;
            ST_PWR:       if (cnt_reg == n_reg) state_next = ST_FR;
            ST_FR:        state_next = ST_MACC;
            ST_MACC:      if (k_reg == 3'd4) state_next = ST_DIVC_GO;
            ST_DIVC_GO:   state_next = ST_DIVC_WAIT;
            ST_DIVC_WAIT: if (div_stat.done) state_next = ST_FACE;
            ST_FACE:      state_next = ST_SUM;
            ST_SUM:       state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        out_free      = !m_valid_reg || m_ready;
        div_ctl.start = (state_reg == ST_DIVD_GO) || (state_reg == ST_DIVC_GO);
        div_ctl.iters = (state_reg == ST_DIVC_GO) ? ITER_W'(DIV_ITERS_C) : ITER_W'(DIV_ITERS_D);
        div_rem       = (state_reg == ST_DIVC_GO) ? '0 : {freq_reg, {YIELD_W{1'b0}}};
        div_dvd       = (state_reg == ST_DIVC_GO) ? acc_reg : '0;
        div_den       = (state_reg == ST_DIVC_GO) ? REM_W'(freq_reg) : den_reg;
        mul_a         = '0;
        mul_b         = '0;
        unique case (state_reg)
            ST_PWR: begin
                mul_a = p_reg;
                mul_b = d_reg;
            end
            ST_FR: begin
                mul_a = MUL_W'(face_reg);
                mul_b = MUL_W'(rate_reg);
            end
            ST_MACC: begin
                mul_a = k_reg[0] ? MUL_W'(x_reg[X_W-1:XLO_W]) : MUL_W'(x_reg[XLO_W-1:0]);
                mul_b = k_reg[1] ? MUL_W'(sum_reg[SUM_W-1:SLO_W]) : MUL_W'(sum_reg[SLO_W-1:0]);
            end
            ST_FACE: begin
                mul_a = MUL_W'(face_reg);
                mul_b = p_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            face_reg <= s_par_amount;
            rate_reg <= s_coupon_frac;
            freq_reg <= freq_c;
            n_reg    <= n_c;
            den_reg  <= den_c;
            p_reg    <= ONE_FX;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            k_reg    <= '0;
            acc_reg  <= '0;
        end
        unique case (state_reg)
            ST_DIVD_WAIT: begin
                if (div_stat.done) d_reg <= d_c[D_W:1];
            end
            ST_PWR: begin
                if (cnt_reg != n_reg) p_reg <= p_new;
                if (cnt_reg != '0) sum_reg <= sum_reg + SUM_W'(p_reg);
                cnt_reg <= cnt_reg + N_W'(1);
            end
            ST_FR: begin
                x_reg <= mul_p[X_W-1:0];
            end
            ST_MACC: begin
                if (k_reg != 3'd4) prod_reg <= mul_p;
                if (k_reg != 3'd0) acc_reg <= acc_reg + addend;
                k_reg <= k_reg + 3'd1;
            end
            ST_FACE: begin
                prod_reg <= mul_p;
                cp_reg   <= cp_rnd[ACC_W:CP_SHIFT];
            end
            ST_SUM: begin
                price_reg <= (psum > PSUM_W'(PRICE_MAX)) ? PRICE_MAX : psum[PRICE_W-1:0];
            end
            ST_DONE: begin
                if (out_free) m_bond_price_reg <= price_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_bond_price = m_bond_price_reg;

endmodule

>>> sv/cbp_checker.sv
// cbp_checker: port-level assertions for coupon_bond_price, attached by bind
// depends on cbp_pkg and the coupon_bond_price port list
`timescale 1ns / 1ps

module cbp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [cbp_pkg::PRICE_W-1:0] m_bond_price
);
    import cbp_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bond_price))
        else $error("result dropped or changed while stalled");

    // one bond at a time
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a bond is in work");

    // no result right after a transfer into an empty output
    a_no_instant_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared with no work done");

    // clean state after reset
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind coupon_bond_price cbp_checker u_cbp_checker (.*);

>>> test/coupon_bond_price_test.sv
// coupon_bond_price_test: self-checking testbench for coupon_bond_price, one bond per transfer
// predicts each price in fixed point and checks every result in order; depends on cbp_pkg
`timescale 1ns / 1ps

module coupon_bond_price_test;

    import cbp_pkg::*;

    localparam int CALM_ITEMS     = 60;
    localparam int HOLD_CYCLES    = 3000;
    localparam int HOLD_AFTER     = 40;
    localparam int DRAIN_CYCLES   = 1500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 440;

    typedef struct packed {
        logic [YIELD_W-1:0] annual_yield;
        logic [RATE_W-1:0]  coupon_frac;
        logic [FACE_W-1:0]  par_amount;
        logic [FREQ_W-1:0]  coupons_per_year;
        logic [YEARS_W-1:0] maturity_years;
        bit                 drain;
    } bond_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [YIELD_W-1:0]  s_annual_yield = '0;
    logic [RATE_W-1:0]   s_coupon_frac = '0;
    logic [FACE_W-1:0]   s_par_amount = '0;
    logic [FREQ_W-1:0]   s_coupons_per_year = '0;
    logic [YEARS_W-1:0]  s_maturity_years = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [PRICE_W-1:0]  m_bond_price;

    bond_t               bond_q[$];
    logic [PRICE_W-1:0]  pending_prices[$];
    bond_t               bond_on_bus;
    int                  total_bonds;
    int                  bonds_taken;
    int                  prices_checked;
    int                  send_gap;
    int                  stall_cnt;
    int                  hold_cnt;
    int                  idle_cycles;
    bit                  held;
    bit                  calm;
    bit                  failed;

    coupon_bond_price dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_annual_yield     (s_annual_yield),
        .s_coupon_frac      (s_coupon_frac),
        .s_par_amount       (s_par_amount),
        .s_coupons_per_year (s_coupons_per_year),
        .s_maturity_years   (s_maturity_years),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_bond_price       (m_bond_price)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [PRICE_W-1:0] bond_present_value(bond_t b);
        logic [4:0]   freq;
        logic [6:0]   years;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [63:0]  quo;
        logic [63:0]  rem;
        logic [32:0]  disc;
        logic [32:0]  pw;
        logic [63:0]  pw_sum;
        logic [127:0] acc;
        logic [127:0] coupon_part;
        logic [127:0] face_part;
        logic [127:0] total;
        int           periods;
        int           k;
        freq = (b.coupons_per_year == 0) ? 5'd1 : 5'(b.coupons_per_year);
        if (freq > MAX_COUPONS_PER_YEAR)
            freq = 5'(MAX_COUPONS_PER_YEAR);
        years = b.maturity_years;
        if (years > MAX_MATURITY_YEARS)
            years = 7'(MAX_MATURITY_YEARS);
        periods = int'(years) * int'(freq);

        // discount factor 1 / (1 + yield / freq), one extra bit then round half up
        num = 64'(freq) << 16;
        den = num + 64'(b.annual_yield);
        if (b.annual_yield == 0) begin
            disc = ONE_FX;
        end else begin
            quo = '0;
            rem = num;
            for (k = 0; k <= FRAC_BITS; k++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    quo[0] = 1'b1;
                end
            end
            disc = 33'((quo + 64'd1) >> 1);
        end

        pw = ONE_FX;
        pw_sum = '0;
        for (k = 0; k < periods; k++) begin
            acc = 128'(pw) * 128'(disc);
            pw = 33'((acc + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
            pw_sum = pw_sum + 64'(pw);
        end

        acc = 128'(b.par_amount) * 128'(b.coupon_frac) * 128'(pw_sum);
        acc = acc / 128'(freq);
        coupon_part = (acc + (128'd1 << (FRAC_BITS + 7))) >> (FRAC_BITS + 8);
        face_part = (128'(b.par_amount) * 128'(pw) + (128'd1 << (FRAC_BITS - 9)))
                    >> (FRAC_BITS - 8);

        if (coupon_part > 128'(PRICE_MAX) || face_part > 128'(PRICE_MAX))
            return PRICE_MAX;
        total = coupon_part + face_part;
        if (total > 128'(PRICE_MAX))
            return PRICE_MAX;
        return total[PRICE_W-1:0];
    endfunction

    function automatic bond_t make_bond(logic [YIELD_W-1:0] yld, logic [RATE_W-1:0] rate,
                                        logic [FACE_W-1:0] face, logic [FREQ_W-1:0] freq,
                                        logic [YEARS_W-1:0] years);
        bond_t b;
        b.annual_yield     = yld;
        b.coupon_frac      = rate;
        b.par_amount       = face;
        b.coupons_per_year = freq;
        b.maturity_years   = years;
        b.drain            = 1'b0;
        return b;
    endfunction

    function automatic bond_t random_bond();
        bond_t       b;
        int unsigned pick;
        b.annual_yield = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8000))
                                                      : 16'($urandom);
        b.coupon_frac  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8000))
                                                      : 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 3)
            b.par_amount = $urandom;
        else if (pick < 8)
            b.par_amount = $urandom_range(0, 1000000);
        else if (pick == 8)
            b.par_amount = '1;
        else
            b.par_amount = '0;
        if ($urandom_range(0, 6) == 0)
            b.coupons_per_year = ($urandom_range(0, 3) == 0) ? 4'd0
                                                              : 4'($urandom_range(13, 15));
        else
            b.coupons_per_year = 4'($urandom_range(1, 12));
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            b.maturity_years = 7'($urandom_range(0, 6));
        end else if (pick < 94) begin
            b.maturity_years = 7'($urandom_range(7, 40));
        end else if (pick < 98) begin
            b.maturity_years = 7'($urandom_range(41, 127));
        end else begin
            b.maturity_years = ($urandom_range(0, 1) == 0) ? 7'd100 : 7'd127;
            b.coupons_per_year = 4'd12;
        end
        b.drain = ($urandom_range(0, 63) == 0);
        return b;
    endfunction

    // driver: one bond on the bus at a time, random gaps between transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_prices.push_back(bond_present_value(bond_on_bus));
                bonds_taken++;
            end
            if (!s_valid || s_ready) begin
                calm = (bond_q.size() < CALM_ITEMS);
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (bond_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!calm && bond_q[0].drain && pending_prices.size() != 0) begin
                    s_valid <= 1'b0;
                end else begin
                    bond_on_bus = bond_q.pop_front();
                    s_annual_yield     <= bond_on_bus.annual_yield;
                    s_coupon_frac      <= bond_on_bus.coupon_frac;
                    s_par_amount       <= bond_on_bus.par_amount;
                    s_coupons_per_year <= bond_on_bus.coupons_per_year;
                    s_maturity_years   <= bond_on_bus.maturity_years;
                    s_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 7);
                end
            end
        end
    end

    // monitor: checks each price transfer against the oldest prediction
    always @(posedge aclk) begin
        logic [PRICE_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_prices.size() == 0) begin
                    $error("bond_price: no price expected, got %0d", m_bond_price);
                    failed = 1'b1;
                end else begin
                    want = pending_prices.pop_front();
                    if (m_bond_price !== want) begin
                        $error("bond_price: expected %0d, got %0d", want, m_bond_price);
                        failed = 1'b1;
                    end
                end
                prices_checked++;
            end
            // long back-pressure so the block fills up and stalls its input
            if (!held && prices_checked >= HOLD_AFTER) begin
                held = 1'b1;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_cnt = $urandom_range(1, 7);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bond_t b;
        int    i;
        // corner cases: zero frequency and maturity, clamping, saturation, bit patterns
        bond_q.push_back(make_bond('0, '0, '0, 4'd0, 7'd0));
        bond_q.push_back(make_bond('0, '1, '1, 4'd12, 7'd100));
        bond_q.push_back(make_bond('1, '1, '1, 4'd15, 7'd127));
        bond_q.push_back(make_bond('1, '0, '1, 4'd1, 7'd1));
        bond_q.push_back(make_bond(16'h0ccd, 16'h0ccd, 32'd1000, 4'd2, 7'd10));
        bond_q.push_back(make_bond(16'd1, 16'd1, 32'd1, 4'd1, 7'd1));
        bond_q.push_back(make_bond(16'h1000, 16'h2000, '1, 4'd12, 7'd0));
        bond_q.push_back(make_bond(16'h0800, 16'h0800, 32'd100000, 4'd13, 7'd101));
        bond_q.push_back(make_bond('1, 16'h4000, 32'd5000000, 4'd1, 7'd100));
        bond_q.push_back(make_bond('0, '1, '1, 4'd1, 7'd1));
        bond_q.push_back(make_bond(16'haaaa, 16'h5555, 32'haaaaaaaa, 4'd10, 7'h55));
        bond_q.push_back(make_bond(16'h5555, 16'haaaa, 32'h55555555, 4'd5, 7'h2a));
        bond_q.push_back(make_bond(16'h0001, '1, '1, 4'd14, 7'd3));
        bond_q.push_back(make_bond('1, '1, 32'd1, 4'd4, 7'd0));
        bond_q.push_back(make_bond(16'h0200, 16'h0300, 32'd1000000, 4'd6, 7'd5));
        bond_q.push_back(make_bond('0, '0, '1, 4'd0, 7'd64));
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            b = random_bond();
            if (i == 0)
                b.drain = 1'b1;
            bond_q.push_back(b);
        end
        total_bonds = bond_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (bonds_taken < total_bonds || pending_prices.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (!failed && pending_prices.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/cbp_pkg.sv
sv/cbp_div.sv
sv/coupon_bond_price.sv
sv/cbp_checker.sv
test/coupon_bond_price_test.sv
